>>> rtl/plr_pkg.sv
// Shared constants and codes for the palette linear resampler.
// Used by palette_linear_resample; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package plr_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int FRACTION_BITS = 16;

  localparam int ADDR_W   = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W  = ADDR_W + 1;
  localparam int CHAN_W   = 8;
  localparam int CHANNELS = 3;
  localparam int COLOR_W  = CHAN_W * CHANNELS;
  localparam int RATIO_W  = ADDR_W + FRACTION_BITS;
  localparam int PROD_W   = CHAN_W + FRACTION_BITS + 2;
  localparam int DIV_CNT_W = $clog2(RATIO_W + 1);

  localparam logic [0:0] KIND_STORE = 1'b0;
  localparam logic [0:0] KIND_READ  = 1'b1;

  localparam logic [0:0] CFG_SOURCE_COUNT = 1'b0;
  localparam logic [0:0] CFG_TARGET_COUNT = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(PALETTE_DEPTH);

endpackage

`default_nettype wire

>>> rtl/plr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module plr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/palette_linear_resample.sv
// Top level of the palette linear resampler: palette store, ratio divider and
// the five-stage lookup and blend pipeline. Depends on plr_pkg and plr_ram.
//
// Usage: an input beat with in_kind store writes one RGB entry at in_index and
// gives no result. A beat with in_kind read returns one result beat: the entry
// for output index in_index, blended linearly between two stored entries when
// the palette is resampled to target_count, plus out_range_error when the
// index is at or beyond the effective count (colors are then zero).
// The configuration port writes source_count and target_count with no wait.
// Each write starts a restoring divider for the resampling ratio, one quotient
// bit per cycle; it blocks input beats until the divider is idle again after
// the last write. Throughput is one beat per cycle while out_ready is high and
// the divider is idle, set by the pipelined multiply and the two palette read
// ports. Store beats pass the same pipeline and write the palette at the
// stage where reads are issued, so order is kept.
// Reset clears valid bits and sets both counts to 256; palette contents are
// undefined until written. When out_ready is low the result register holds,
// and upstream stages keep filling until every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module palette_linear_resample (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [plr_pkg::COUNT_W-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [0:0]                    in_kind,
  input  wire logic [plr_pkg::ADDR_W-1:0]    in_index,
  input  wire logic [plr_pkg::CHAN_W-1:0]    in_red_in,
  input  wire logic [plr_pkg::CHAN_W-1:0]    in_green_in,
  input  wire logic [plr_pkg::CHAN_W-1:0]    in_blue_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [plr_pkg::CHAN_W-1:0]         out_red_out,
  output logic [plr_pkg::CHAN_W-1:0]         out_green_out,
  output logic [plr_pkg::CHAN_W-1:0]         out_blue_out,
  output logic                               out_range_error
);

  typedef enum logic [1:0] {DIV_IDLE, DIV_LOAD, DIV_RUN} div_state_t;

  // Configuration.
  logic [plr_pkg::COUNT_W-1:0] source_count_r, target_count_r;
  logic [plr_pkg::COUNT_W-1:0] s_sat, eff_count;
  logic                        rescale;
  logic [plr_pkg::ADDR_W-1:0]  s_m1, t_m1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_count_r <= plr_pkg::COUNT_RESET;
      target_count_r <= plr_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        plr_pkg::CFG_SOURCE_COUNT: source_count_r <= cfg_data;
        plr_pkg::CFG_TARGET_COUNT: target_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s_sat     = (source_count_r > plr_pkg::COUNT_RESET) ? plr_pkg::COUNT_RESET
                                                         : source_count_r;
    rescale   = (s_sat > target_count_r) && (target_count_r > plr_pkg::COUNT_W'(1));
    eff_count = rescale ? target_count_r : s_sat;
    s_m1      = plr_pkg::ADDR_W'(s_sat - plr_pkg::COUNT_W'(1));
    t_m1      = plr_pkg::ADDR_W'(target_count_r - plr_pkg::COUNT_W'(1));
  end

  // Restoring divider for ratio = ((S-1) << FRACTION_BITS) / (T-1).
  div_state_t                    div_state_r;
  logic [plr_pkg::RATIO_W-1:0]   quot_r;
  logic [plr_pkg::ADDR_W-1:0]    rem_r;
  logic [plr_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [plr_pkg::ADDR_W:0]      trial;
  logic                          trial_ge;
  logic                          div_busy;

  always_comb begin
    trial    = {rem_r, quot_r[plr_pkg::RATIO_W-1]};
    trial_ge = trial >= {1'b0, t_m1};
    div_busy = div_state_r != DIV_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
      div_cnt_r   <= '0;
    end else if (cfg_we) begin
      div_state_r <= DIV_LOAD;
    end else begin
      unique case (div_state_r)
        DIV_IDLE: ;
        DIV_LOAD: begin
          quot_r      <= {s_m1, {plr_pkg::FRACTION_BITS{1'b0}}};
          rem_r       <= '0;
          div_cnt_r   <= plr_pkg::DIV_CNT_W'(plr_pkg::RATIO_W);
          div_state_r <= DIV_RUN;
        end
        DIV_RUN: begin
          quot_r    <= {quot_r[plr_pkg::RATIO_W-2:0], trial_ge};
          rem_r     <= trial_ge ? plr_pkg::ADDR_W'(trial - {1'b0, t_m1})
                                : plr_pkg::ADDR_W'(trial);
          div_cnt_r <= div_cnt_r - plr_pkg::DIV_CNT_W'(1);
          if (div_cnt_r == plr_pkg::DIV_CNT_W'(1)) begin
            div_state_r <= DIV_IDLE;
          end
        end
        default: div_state_r <= DIV_IDLE;
      endcase
    end
  end

  // Pipeline control.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic ld1, ld2, ld3, ld4, ld_out, accept;

  always_comb begin
    ld_out   = !out_valid_r || out_ready;
    ld4      = !v4_r || ld_out;
    ld3      = !v3_r || ld4;
    ld2      = !v2_r || ld3;
    ld1      = !v1_r || ld2;
    in_ready = ld1 && !div_busy && !cfg_we;
    accept   = in_valid && in_ready;
  end

  // Stage 1: input register.
  logic [0:0]                   kind1_r;
  logic [plr_pkg::ADDR_W-1:0]   idx1_r;
  logic [plr_pkg::COLOR_W-1:0]  rgb1_r;

  // Stage 2: position.
  logic [0:0]                   kind2_r;
  logic [plr_pkg::ADDR_W-1:0]   idx2_r;
  logic [plr_pkg::COLOR_W-1:0]  rgb2_r;
  logic                         err2_r, resc2_r;
  logic [plr_pkg::RATIO_W-1:0]  pos2_r;

  logic [plr_pkg::ADDR_W-1:0]   base_slot, next_cell, addr0, addr1;
  logic [plr_pkg::FRACTION_BITS-1:0] frac2;
  logic [plr_pkg::COUNT_W-1:0]  cell_inc;
  logic                         ram_we;

  always_comb begin
    base_slot = pos2_r[plr_pkg::RATIO_W-1:plr_pkg::FRACTION_BITS];
    cell_inc  = {1'b0, base_slot} + plr_pkg::COUNT_W'(1);
    next_cell = (cell_inc >= s_sat) ? base_slot : plr_pkg::ADDR_W'(cell_inc);
    addr0     = resc2_r ? base_slot : idx2_r;
    addr1     = resc2_r ? next_cell : idx2_r;
    frac2     = resc2_r ? pos2_r[plr_pkg::FRACTION_BITS-1:0] : '0;
    ram_we    = ld3 && v2_r && (kind2_r == plr_pkg::KIND_STORE);
  end

  // Stage 3: palette data.
  logic                              err3_r;
  logic [plr_pkg::FRACTION_BITS-1:0] frac3_r;
  logic [plr_pkg::COLOR_W-1:0]       rd0, rd1;

  plr_ram #(
    .WIDTH(plr_pkg::COLOR_W),
    .DEPTH(plr_pkg::PALETTE_DEPTH)
  ) u_ram0 (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx2_r),
    .wr_data (rgb2_r),
    .rd_en   (ld3),
    .rd_addr (addr0),
    .rd_data (rd0)
  );

  plr_ram #(
    .WIDTH(plr_pkg::COLOR_W),
    .DEPTH(plr_pkg::PALETTE_DEPTH)
  ) u_ram1 (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx2_r),
    .wr_data (rgb2_r),
    .rd_en   (ld3),
    .rd_addr (addr1),
    .rd_data (rd1)
  );

  // Stage 4: blend products.
  logic                              err4_r;
  logic [plr_pkg::CHAN_W-1:0]        base4_r [plr_pkg::CHANNELS];
  logic signed [plr_pkg::PROD_W-1:0] prod4_r [plr_pkg::CHANNELS];

  logic [plr_pkg::CHAN_W-1:0]        c0 [plr_pkg::CHANNELS];
  logic [plr_pkg::CHAN_W-1:0]        c1 [plr_pkg::CHANNELS];
  logic signed [plr_pkg::CHAN_W:0]   diff [plr_pkg::CHANNELS];
  logic signed [plr_pkg::FRACTION_BITS:0] frac_s;
  logic signed [plr_pkg::PROD_W-1:0] prod [plr_pkg::CHANNELS];
  logic signed [plr_pkg::PROD_W-1:0] sum [plr_pkg::CHANNELS];
  logic [plr_pkg::CHAN_W-1:0]        chan_res [plr_pkg::CHANNELS];

  always_comb begin
    frac_s = $signed({1'b0, frac3_r});
    for (int k = 0; k < plr_pkg::CHANNELS; k++) begin
      c0[k]   = rd0[(plr_pkg::CHANNELS-1-k)*plr_pkg::CHAN_W +: plr_pkg::CHAN_W];
      c1[k]   = rd1[(plr_pkg::CHANNELS-1-k)*plr_pkg::CHAN_W +: plr_pkg::CHAN_W];
      diff[k] = $signed({1'b0, c1[k]}) - $signed({1'b0, c0[k]});
      prod[k] = plr_pkg::PROD_W'(diff[k]) * plr_pkg::PROD_W'(frac_s);
      sum[k]  = $signed({2'b00, base4_r[k], {plr_pkg::FRACTION_BITS{1'b0}}})
                + prod4_r[k];
      chan_res[k] = sum[k][plr_pkg::FRACTION_BITS +: plr_pkg::CHAN_W];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= accept;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        v3_r <= v2_r && (kind2_r == plr_pkg::KIND_READ);
      end
      if (ld4) begin
        v4_r <= v3_r;
      end
      if (ld_out) begin
        out_valid_r <= v4_r;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ld1) begin
      kind1_r <= in_kind;
      idx1_r  <= in_index;
      rgb1_r  <= {in_red_in, in_green_in, in_blue_in};
    end
    if (ld2) begin
      kind2_r <= kind1_r;
      idx2_r  <= idx1_r;
      rgb2_r  <= rgb1_r;
      err2_r  <= {1'b0, idx1_r} >= eff_count;
      resc2_r <= rescale;
      pos2_r  <= plr_pkg::RATIO_W'(idx1_r * quot_r);
    end
    if (ld3) begin
      err3_r  <= err2_r;
      frac3_r <= frac2;
    end
    if (ld4) begin
      err4_r <= err3_r;
      for (int k = 0; k < plr_pkg::CHANNELS; k++) begin
        base4_r[k] <= c0[k];
        prod4_r[k] <= prod[k];
      end
    end
    if (ld_out) begin
      out_range_error <= err4_r;
      out_red_out     <= err4_r ? '0 : chan_res[0];
      out_green_out   <= err4_r ? '0 : chan_res[1];
      out_blue_out    <= err4_r ? '0 : chan_res[2];
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
